// ----- sv/hcl_pkg.sv -----
`default_nettype none
package hcl_pkg;

	localparam int POS_W = 6;
	localparam logic [POS_W-1:0] POS_CAP = '1;

	localparam logic [1:0] KIND_SET  = 2'd0;
	localparam logic [1:0] KIND_GET  = 2'd1;
	localparam logic [1:0] KIND_MAC  = 2'd2;
	// command code with no line format behind it
	localparam logic [1:0] KIND_NONE = 2'd3;

	localparam logic [1:0] STATUS_OK  = 2'd0;
	localparam logic [1:0] STATUS_FMT = 2'd1;
	localparam logic [1:0] STATUS_CHK = 2'd2;

	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_COLON = 8'h3a;

	localparam int SG_KEY_LEN  = 3;
	localparam int MAC_KEY_LEN = 6;

	typedef enum logic [3:0] {
		ROLE_SKIP, ROLE_SPACE, ROLE_ADDR, ROLE_DATA, ROLE_MACHI, ROLE_MACLO,
		ROLE_COLON, ROLE_CHKHI, ROLE_CHKLO, ROLE_END, ROLE_BAD
	} role_t;

	typedef enum logic [1:0] {
		PH_HI, PH_LO, PH_COLON
	} phase_t;

	typedef struct packed {
		logic [7:0] char_in;
		logic [1:0] command;
	} char_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [1:0]  kind;
		logic [11:0] address;
		logic [7:0]  data_byte;
		logic [47:0] mac_address;
	} result_word_t;

	typedef struct packed {
		logic         valid;
		result_word_t word;
	} result_bus_t;

	// returns {valid, nibble}
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- sv/hcl_role.sv -----
`default_nettype none
module hcl_role #(
	parameter int ADDR_DIGITS = 3,
	parameter int MAC_BYTES = 6
) (
	input  wire logic [1:0]                kind,
	input  wire logic [hcl_pkg::POS_W-1:0] pos,
	input  wire hcl_pkg::phase_t           phase,
	output hcl_pkg::role_t                 role
);
	import hcl_pkg::*;

	localparam int SG_ADDR0  = SG_KEY_LEN + 1;
	localparam int SG_SP1    = SG_ADDR0 + ADDR_DIGITS;
	localparam int SET_DATA0 = SG_SP1 + 1;
	localparam int SET_SP2   = SET_DATA0 + 2;
	localparam int SET_CHK0  = SET_SP2 + 1;
	localparam int GET_CHK0  = SG_SP1 + 1;
	localparam int MAC0      = MAC_KEY_LEN + 1;
	localparam int MAC_SP    = MAC0 + 3 * MAC_BYTES - 1;
	localparam int MAC_CHK0  = MAC_SP + 1;

	logic [POS_W-1:0] chk0;

	always_comb begin
		unique case (kind)
			KIND_SET: chk0 = POS_W'(SET_CHK0);
			KIND_GET: chk0 = POS_W'(GET_CHK0);
			default:  chk0 = POS_W'(MAC_CHK0);
		endcase
	end

	always_comb begin
		role = ROLE_BAD;
		if (kind == KIND_MAC) begin
			if (pos < POS_W'(MAC_KEY_LEN)) begin
				role = ROLE_SKIP;
			end else if (pos == POS_W'(MAC_KEY_LEN)) begin
				role = ROLE_SPACE;
			end else if (pos < POS_W'(MAC_SP)) begin
				unique case (phase)
					PH_HI:   role = ROLE_MACHI;
					PH_LO:   role = ROLE_MACLO;
					default: role = ROLE_COLON;
				endcase
			end else if (pos == POS_W'(MAC_SP)) begin
				role = ROLE_SPACE;
			end
		end else if (kind == KIND_SET || kind == KIND_GET) begin
			if (pos < POS_W'(SG_KEY_LEN)) begin
				role = ROLE_SKIP;
			end else if (pos == POS_W'(SG_KEY_LEN)) begin
				role = ROLE_SPACE;
			end else if (pos < POS_W'(SG_SP1)) begin
				role = ROLE_ADDR;
			end else if (pos == POS_W'(SG_SP1)) begin
				role = ROLE_SPACE;
			end else if (kind == KIND_SET && pos < POS_W'(SET_SP2)) begin
				role = ROLE_DATA;
			end else if (kind == KIND_SET && pos == POS_W'(SET_SP2)) begin
				role = ROLE_SPACE;
			end
		end
		if (kind != KIND_NONE) begin
			if (pos == chk0) begin
				role = ROLE_CHKHI;
			end else if (pos == chk0 + POS_W'(1)) begin
				role = ROLE_CHKLO;
			end else if (pos == chk0 + POS_W'(2)) begin
				role = ROLE_END;
			end else if (pos > chk0 + POS_W'(2)) begin
				role = ROLE_BAD;
			end
		end
	end

endmodule
`default_nettype wire

// ----- sv/hcl_core.sv -----
`default_nettype none
module hcl_core #(
	parameter int ADDR_DIGITS = 3,
	parameter int MAC_BYTES = 6
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                fire,
	input  wire hcl_pkg::char_word_t word_s1,
	input  wire logic                result_stall,
	output hcl_pkg::result_bus_t     result
);
	import hcl_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [1:0]       kind_q;
	logic             ferr_q;
	logic [11:0]      addr_q;
	logic [7:0]       data_q;
	logic [47:0]      mac_q;
	logic [7:0]       chk_q;
	phase_t           phase_q;

	logic             res_valid_q;
	result_word_t     res_word_q;

	logic [1:0]  kind_eff;
	role_t       role;
	logic [4:0]  hex;
	logic [3:0]  nib;
	logic        eol;
	logic [7:0]  sum;
	logic [1:0]  status;
	logic [47:0] mac_next;

	assign kind_eff = (pos_q == '0) ? word_s1.command : kind_q;
	assign eol      = (word_s1.char_in == CH_LF) || (word_s1.char_in == CH_CR);
	assign hex      = hex_digit(word_s1.char_in);
	assign nib      = hex[3:0];
	assign mac_next = {mac_q[43:0], nib};

	hcl_role #(.ADDR_DIGITS(ADDR_DIGITS), .MAC_BYTES(MAC_BYTES)) u_role (
		.kind  (kind_eff),
		.pos   (pos_q),
		.phase (phase_q),
		.role  (role)
	);

	always_comb begin
		sum = chk_q;
		if (kind_eff == KIND_SET) begin
			sum = chk_q + addr_q[7:0] + data_q;
		end else if (kind_eff == KIND_GET) begin
			sum = chk_q + addr_q[7:0];
		end
		if (ferr_q || role != ROLE_END) begin
			status = STATUS_FMT;
		end else if (sum == 8'd0) begin
			status = STATUS_OK;
		end else begin
			status = STATUS_CHK;
		end
	end

	// per-line state, cleared at every line end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			kind_q  <= KIND_SET;
			ferr_q  <= 1'b0;
			addr_q  <= '0;
			data_q  <= '0;
			mac_q   <= '0;
			chk_q   <= '0;
			phase_q <= PH_HI;
		end else if (fire) begin
			if (eol) begin
				pos_q   <= '0;
				kind_q  <= KIND_SET;
				ferr_q  <= 1'b0;
				addr_q  <= '0;
				data_q  <= '0;
				mac_q   <= '0;
				chk_q   <= '0;
				phase_q <= PH_HI;
			end else begin
				kind_q <= kind_eff;
				if (pos_q != POS_CAP) begin
					pos_q <= pos_q + POS_W'(1);
				end
				case (role)
					ROLE_MACHI: phase_q <= PH_LO;
					ROLE_MACLO: phase_q <= PH_COLON;
					ROLE_COLON: phase_q <= PH_HI;
					default: ;
				endcase
				case (role)
					ROLE_SKIP: ;
					ROLE_SPACE: begin
						if (word_s1.char_in != CH_SPACE) ferr_q <= 1'b1;
					end
					ROLE_COLON: begin
						if (word_s1.char_in != CH_COLON) ferr_q <= 1'b1;
					end
					ROLE_ADDR, ROLE_DATA, ROLE_MACHI, ROLE_MACLO, ROLE_CHKHI,
					ROLE_CHKLO: begin
						if (!hex[4]) begin
							ferr_q <= 1'b1;
						end else if (role == ROLE_ADDR) begin
							addr_q <= {addr_q[7:0], nib};
						end else if (role == ROLE_DATA) begin
							data_q <= {data_q[3:0], nib};
						end else if (role == ROLE_MACHI) begin
							mac_q <= mac_next;
						end else if (role == ROLE_MACLO) begin
							mac_q <= mac_next;
							chk_q <= chk_q + mac_next[7:0];
						end else if (role == ROLE_CHKHI) begin
							chk_q <= chk_q - {nib, 4'd0};
						end else begin
							chk_q <= chk_q - {4'd0, nib};
						end
					end
					default: ferr_q <= 1'b1;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire && eol) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && eol) begin
			res_word_q.status      <= status;
			res_word_q.kind        <= kind_eff;
			res_word_q.address     <= addr_q;
			res_word_q.data_byte   <= data_q;
			res_word_q.mac_address <= mac_q;
		end
	end

	assign result.valid = res_valid_q;
	assign result.word  = res_word_q;

endmodule
`default_nettype wire

// ----- sv/hex_command_line_parser.sv -----
`default_nettype none
// Parses a serial command line one character per word. The command kind is
// sampled with the first character of a line: set ("KKK AAA DD CC"), get
// ("KKK AAA CC") or mac set ("KKKKKK HH:HH:HH:HH:HH:HH CC"). The keyword is
// skipped; spaces, hex digits (either case), colons and the checksum are
// checked. Every CR or LF ends the line and yields exactly one result word
// with status ok, format error or checksum error, plus the fields parsed so
// far (fields that a kind does not parse read zero). Characters with no
// result produce nothing on the result side. Throughput is one character
// per clock while no result is held back; the result of an accepted line
// end passes through the input register and then the result register. The
// per-line state lives in a single registered update loop in the core, so
// back-to-back characters are processed without bubbles. The input stalls
// only while a result waits, stalled, in the result register.
module hex_command_line_parser #(
	parameter int ADDR_DIGITS = 3,
	parameter int MAC_BYTES = 6
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  char_valid,
	output logic                       char_stall,
	input  wire hcl_pkg::char_word_t   char_word,
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output hcl_pkg::result_word_t      result_word
);
	import hcl_pkg::*;

	// input register
	logic        valid_s1;
	char_word_t  word_s1;
	logic        advance;
	logic        fire;
	logic        accept;
	result_bus_t result;

	// the input stage drains unless a finished result is still held back
	assign advance    = !(result.valid && result_stall);
	assign fire       = valid_s1 && advance;
	assign char_stall = valid_s1 && !advance;
	assign accept     = char_valid && !char_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= char_word;
		end
	end

	// line state and result register
	hcl_core #(.ADDR_DIGITS(ADDR_DIGITS), .MAC_BYTES(MAC_BYTES)) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.word_s1      (word_s1),
		.result_stall (result_stall),
		.result       (result)
	);

	assign result_valid = result.valid;
	assign result_word  = result.word;

	// a clean line always has a known kind
	a_ok_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_word.status == STATUS_OK |-> result_word.kind != KIND_NONE)
		else $error("ok status reported for unused kind");

	// the input side only stalls with an occupied input register and a result waiting
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		char_stall |-> valid_s1 && result_valid)
		else $error("input stalled with nothing waiting");

	// a mac line never carries set/get fields
	a_mac_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_word.kind == KIND_MAC
		|-> result_word.address == 12'd0 && result_word.data_byte == 8'd0)
		else $error("mac result carries address or data");

	// a get line never carries a data byte or mac
	a_get_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_word.kind == KIND_GET
		|-> result_word.data_byte == 8'd0 && result_word.mac_address == 48'd0)
		else $error("get result carries data or mac");

endmodule
`default_nettype wire
